/* hdl/rc4_pkg.sv */
// rc4 cipher package: widths, controller states, datapath op codes and
// the command and status structs between controller and datapath
// no dependencies
package rc4_pkg;

	localparam int MAX_KEY_BYTES_DEF = 256;
	localparam int BYTE_W            = 8;
	localparam int LEN_W             = 9;
	localparam int PERM_DEPTH        = 256;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_KS_RD_N,
		ST_KS_RD_A,
		ST_KS_WR_N,
		ST_KS_WR_A,
		ST_RD_I,
		ST_RD_J,
		ST_WR_I,
		ST_WR_J,
		ST_OUT
	} rc4_state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_INIT,
		OP_KS_RD_N,
		OP_KS_RD_A,
		OP_KS_WR_N,
		OP_KS_WR_A,
		OP_RD_I,
		OP_RD_J,
		OP_WR_I,
		OP_WR_J,
		OP_OUT
	} rc4_op_t;

	typedef struct packed {
		rc4_op_t op;
		logic    load_item;
		logic    key_we;
		logic    clr_ij;
	} rc4_cmd_t;

	typedef struct packed {
		logic n_last;
		logic out_stall;
	} rc4_status_t;

endpackage

/* hdl/rc4_if.sv */
// valid/ready channel interfaces of the rc4 cipher: input items,
// result items and the key length write channel
// depends on rc4_pkg
interface rc4_item_if;
	import rc4_pkg::*;
	logic              valid;
	logic              ready;
	logic              action;
	logic [BYTE_W-1:0] value;
	logic [BYTE_W-1:0] key_index;
	logic              message_start;

	modport source (output valid, action, value, key_index, message_start, input ready);
	modport sink   (input valid, action, value, key_index, message_start, output ready);
endinterface

interface rc4_result_if;
	import rc4_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;

	modport source (output valid, out_byte, input ready);
	modport sink   (input valid, out_byte, output ready);
endinterface

interface rc4_cfg_if;
	import rc4_pkg::*;
	logic             valid;
	logic             ready;
	logic [LEN_W-1:0] key_length;

	modport source (output valid, key_length, input ready);
	modport sink   (input valid, key_length, output ready);
endinterface

/* hdl/rc4_stream_cipher.sv */
// rc4 stream cipher top level: controller, datapath and channel wiring
// key write: accepted in idle, no result. data item: read i, read j, write i,
// write j and output steps; the result is loaded in the output step, which waits
// while a stalled result still holds the output stage, and the next item follows it
// message start or first data item after reset first runs the key schedule: a fill
// of all 256 permutation entries, then two reads and two writes for each of 256 entries
// reset clears control, indexes and key length (1); the permutation is refilled
module rc4_stream_cipher #(
	parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	rc4_item_if.sink     data_in,
	rc4_result_if.source data_out,
	rc4_cfg_if.sink      cfg
);
	import rc4_pkg::*;

	rc4_cmd_t    cmd;
	rc4_status_t status;

	assign cfg.ready = 1'b1;

	rc4_ctrl u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (data_in.valid),
		.in_action        (data_in.action),
		.in_message_start (data_in.message_start),
		.in_ready         (data_in.ready),
		.status           (status),
		.cmd              (cmd)
	);

	rc4_dp #(
		.MAX_KEY_BYTES (MAX_KEY_BYTES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.in_value       (data_in.value),
		.in_key_index   (data_in.key_index),
		.cfg_we         (cfg.valid),
		.cfg_key_length (cfg.key_length),
		.out_valid      (data_out.valid),
		.out_ready      (data_out.ready),
		.out_byte       (data_out.out_byte)
	);
endmodule

/* hdl/rc4_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
module rc4_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* hdl/rc4_ctrl.sv */
// rc4 controller: sequences key writes, the key schedule and the
// keystream step of one data item; depends on rc4_pkg
module rc4_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_action,
	input  logic                 in_message_start,
	output logic                 in_ready,
	input  rc4_pkg::rc4_status_t status,
	output rc4_pkg::rc4_cmd_t    cmd
);
	import rc4_pkg::*;

	rc4_state_t state_q, state_d;
	logic       done_q, done_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		done_d        = done_q;
		in_ready      = 1'b0;
		cmd.op        = OP_NONE;
		cmd.load_item = 1'b0;
		cmd.key_we    = 1'b0;
		cmd.clr_ij    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (!in_action) begin
						cmd.key_we = 1'b1;
					end else begin
						cmd.load_item = 1'b1;
						if (in_message_start || !done_q) begin
							state_d = ST_INIT;
						end else begin
							state_d = ST_RD_I;
						end
					end
				end
			end
			ST_INIT: begin
				cmd.op = OP_INIT;
				if (status.n_last) begin
					state_d = ST_KS_RD_N;
				end
			end
			ST_KS_RD_N: begin
				cmd.op  = OP_KS_RD_N;
				state_d = ST_KS_RD_A;
			end
			ST_KS_RD_A: begin
				cmd.op  = OP_KS_RD_A;
				state_d = ST_KS_WR_N;
			end
			ST_KS_WR_N: begin
				cmd.op  = OP_KS_WR_N;
				state_d = ST_KS_WR_A;
			end
			ST_KS_WR_A: begin
				cmd.op = OP_KS_WR_A;
				if (status.n_last) begin
					cmd.clr_ij = 1'b1;
					done_d     = 1'b1;
					state_d    = ST_RD_I;
				end else begin
					state_d = ST_KS_RD_N;
				end
			end
			ST_RD_I: begin
				cmd.op  = OP_RD_I;
				state_d = ST_RD_J;
			end
			ST_RD_J: begin
				cmd.op  = OP_RD_J;
				state_d = ST_WR_I;
			end
			ST_WR_I: begin
				cmd.op  = OP_WR_I;
				state_d = ST_WR_J;
			end
			ST_WR_J: begin
				cmd.op  = OP_WR_J;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				// wait for the output register to free up
				if (!status.out_stall) begin
					cmd.op  = OP_OUT;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end
endmodule

/* hdl/rc4_dp.sv */
// rc4 datapath: permutation and key store rams, indexes, key length
// register and output register; depends on rc4_pkg and rc4_ram
module rc4_dp #(
	parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rc4_pkg::rc4_cmd_t           cmd,
	output rc4_pkg::rc4_status_t        status,
	input  logic [rc4_pkg::BYTE_W-1:0]  in_value,
	input  logic [rc4_pkg::BYTE_W-1:0]  in_key_index,
	input  logic                        cfg_we,
	input  logic [rc4_pkg::LEN_W-1:0]   cfg_key_length,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [rc4_pkg::BYTE_W-1:0]  out_byte
);
	import rc4_pkg::*;

	localparam int KAW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
	localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_KEY_BYTES);

	logic [LEN_W-1:0]  key_length_q;
	logic [LEN_W-1:0]  eff_len;
	logic [LEN_W-1:0]  kidx_q;
	logic [LEN_W-1:0]  kidx_inc;
	logic [BYTE_W-1:0] n_q, acc_q, i_q, j_q, sn_q, si_q, sj_q, value_q;
	logic [BYTE_W-1:0] acc_nx, i_nx, j_nx, sum_ij, ks;
	logic              byp_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;

	logic              p_we, p_re;
	logic [BYTE_W-1:0] p_wa, p_wd, p_ra, p_rd;
	logic              k_we;
	logic [KAW-1:0]    k_wa, k_ra;
	logic [BYTE_W-1:0] k_rd;

	// zero length acts as one, too long saturates at the store size
	always_comb begin
		if (key_length_q == '0) begin
			eff_len = LEN_W'(1);
		end else if (key_length_q > MaxLen) begin
			eff_len = MaxLen;
		end else begin
			eff_len = key_length_q;
		end
	end

	assign kidx_inc = kidx_q + LEN_W'(1);
	assign acc_nx   = acc_q + p_rd + k_rd;
	assign i_nx     = i_q + BYTE_W'(1);
	assign j_nx     = j_q + p_rd;
	assign sum_ij   = si_q + sj_q;
	assign ks       = byp_q ? si_q : p_rd;

	assign k_we = cmd.key_we && ({1'b0, in_key_index} < MaxLen);
	assign k_wa = in_key_index[KAW-1:0];
	assign k_ra = kidx_q[KAW-1:0];

	always_comb begin
		p_we = 1'b0;
		p_re = 1'b0;
		p_wa = n_q;
		p_wd = n_q;
		p_ra = n_q;
		case (cmd.op)
			OP_INIT: begin
				p_we = 1'b1;
			end
			OP_KS_RD_N: begin
				p_re = 1'b1;
			end
			OP_KS_RD_A: begin
				p_re = 1'b1;
				p_ra = acc_nx;
			end
			OP_KS_WR_N: begin
				p_we = 1'b1;
				p_wd = p_rd;
			end
			OP_KS_WR_A: begin
				p_we = 1'b1;
				p_wa = acc_q;
				p_wd = sn_q;
			end
			OP_RD_I: begin
				p_re = 1'b1;
				p_ra = i_nx;
			end
			OP_RD_J: begin
				p_re = 1'b1;
				p_ra = j_nx;
			end
			OP_WR_I: begin
				p_we = 1'b1;
				p_wa = i_q;
				p_wd = p_rd;
			end
			OP_WR_J: begin
				// read of the keystream index shares the cycle with the write
				p_we = 1'b1;
				p_wa = j_q;
				p_wd = si_q;
				p_re = 1'b1;
				p_ra = sum_ij;
			end
			default: begin
				p_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_length_q <= LEN_W'(1);
			i_q          <= '0;
			j_q          <= '0;
			n_q          <= '0;
			kidx_q       <= '0;
			acc_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				key_length_q <= cfg_key_length;
			end
			if (cmd.load_item) begin
				n_q    <= '0;
				kidx_q <= '0;
				acc_q  <= '0;
			end
			if (cmd.op == OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (cmd.op)
				OP_INIT: begin
					n_q <= n_q + BYTE_W'(1);
				end
				OP_KS_RD_A: begin
					acc_q <= acc_nx;
				end
				OP_KS_WR_A: begin
					n_q    <= n_q + BYTE_W'(1);
					kidx_q <= (kidx_inc == eff_len) ? '0 : kidx_inc;
				end
				OP_RD_I: begin
					i_q <= i_nx;
				end
				OP_RD_J: begin
					j_q <= j_nx;
				end
				default: begin
				end
			endcase
			if (cmd.clr_ij) begin
				i_q <= '0;
				j_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			value_q <= in_value;
		end
		case (cmd.op)
			OP_KS_RD_A: begin
				sn_q <= p_rd;
			end
			OP_RD_J: begin
				si_q <= p_rd;
			end
			OP_WR_I: begin
				sj_q <= p_rd;
			end
			OP_WR_J: begin
				byp_q <= (sum_ij == j_q);
			end
			OP_OUT: begin
				out_byte_q <= value_q ^ ks;
			end
			default: begin
			end
		endcase
	end

	assign status.n_last    = (n_q == '1);
	assign status.out_stall = out_valid_q && !out_ready;
	assign out_valid        = out_valid_q;
	assign out_byte         = out_byte_q;

	rc4_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (PERM_DEPTH)
	) u_perm_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_wa),
		.wdata (p_wd),
		.re    (p_re),
		.raddr (p_ra),
		.rdata (p_rd)
	);

	rc4_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (MAX_KEY_BYTES)
	) u_key_ram (
		.clk   (clk),
		.we    (k_we),
		.waddr (k_wa),
		.wdata (in_value),
		.re    (cmd.op == OP_KS_RD_N),
		.raddr (k_ra),
		.rdata (k_rd)
	);
endmodule

/* hdl/rc4_checker.sv */
// port level checks for the rc4 cipher, bound to the top level
// depends on rc4_pkg and rc4_stream_cipher
module rc4_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       in_action,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [rc4_pkg::BYTE_W-1:0] out_byte,
	input logic                       cfg_ready
);
	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte))
		else $error("result item dropped or changed while stalled");

	// a data item keeps the block busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_action |=> !in_ready)
		else $error("input taken while a data item is in work");

	// no result right after a data item is taken
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_action |=> !$rose(out_valid))
		else $error("result item too early");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("key length channel not ready");
endmodule

bind rc4_stream_cipher rc4_checker u_rc4_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (data_in.valid),
	.in_ready  (data_in.ready),
	.in_action (data_in.action),
	.out_valid (data_out.valid),
	.out_ready (data_out.ready),
	.out_byte  (data_out.out_byte),
	.cfg_ready (cfg.ready)
);

/* tb/sv/tb_rc4_stream_cipher.sv */
// self-checking testbench of rc4_stream_cipher: directed rows, then random key and data items
// under changing key lengths, checked byte by byte against a cycle-free cipher predictor
// depends on rc4_pkg, the rc4 channel interfaces and the rc4_stream_cipher rtl
module tb_rc4_stream_cipher;
	import rc4_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 20;
	localparam int ITEMS_PER_PHASE = 50;

	typedef enum bit {
		ACT_KEY_WRITE = 1'b0,
		ACT_DATA      = 1'b1
	} action_t;

	typedef struct packed {
		action_t           action;
		logic [BYTE_W-1:0] value;
		logic [BYTE_W-1:0] key_index;
		logic              message_start;
	} cipher_item_t;

	// directed rows; key length is still 1 here, so only key entry 0 feeds the schedule
	localparam int DIRECTED_ROWS = 14;
	cipher_item_t directed_rows [DIRECTED_ROWS] = '{
		'{ACT_KEY_WRITE, 8'h00, 8'h00, 1'b0},
		'{ACT_KEY_WRITE, 8'hff, 8'hff, 1'b0},
		'{ACT_DATA,      8'h00, 8'h00, 1'b0}, // first data after reset runs the schedule
		'{ACT_DATA,      8'hff, 8'hff, 1'b0},
		'{ACT_DATA,      8'ha5, 8'h00, 1'b1},
		'{ACT_KEY_WRITE, 8'hff, 8'h00, 1'b1}, // message start on a key write is ignored
		'{ACT_DATA,      8'h5a, 8'h00, 1'b0}, // new key not used mid message
		'{ACT_DATA,      8'h00, 8'hff, 1'b0},
		'{ACT_DATA,      8'h00, 8'h00, 1'b1}, // new key now used
		'{ACT_DATA,      8'hff, 8'h00, 1'b1},
		'{ACT_KEY_WRITE, 8'h7f, 8'h80, 1'b0},
		'{ACT_KEY_WRITE, 8'h80, 8'h00, 1'b1},
		'{ACT_DATA,      8'h0f, 8'h00, 1'b1},
		'{ACT_DATA,      8'hf0, 8'hff, 1'b1}
	};

	// key lengths of the random phases, zero and the 9 bit maximum among them
	localparam int PHASES = 9;
	logic [LEN_W-1:0] phase_key_len [PHASES] = '{
		9'd256, 9'd0, 9'd511, 9'd1, 9'd2, 9'd5, 9'd257, 9'd128, 9'd37
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rc4_item_if   item_ch ();
	rc4_result_if result_ch ();
	rc4_cfg_if    cfg_ch ();

	rc4_stream_cipher DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.data_in  (item_ch),
		.data_out (result_ch),
		.cfg      (cfg_ch)
	);

	always #5 clk = ~clk;

	// cipher predictor state
	logic [BYTE_W-1:0] perm [PERM_DEPTH];
	logic [BYTE_W-1:0] key_mem [PERM_DEPTH];
	logic [BYTE_W-1:0] idx_i = '0;
	logic [BYTE_W-1:0] idx_j = '0;
	logic              sched_done = 1'b0;
	logic [LEN_W-1:0]  key_len_reg = 9'd1;

	logic [BYTE_W-1:0] expected_bytes [$];
	int fails = 0;
	int src_idle_pct = 0;
	int sink_idle_pct = 0;
	int quiet_cycles = 0;

	task automatic rekey();
		int len;
		logic [BYTE_W-1:0] acc;
		logic [BYTE_W-1:0] t;
		len = int'(key_len_reg);
		if (len == 0)
			len = 1;
		if (len > PERM_DEPTH)
			len = PERM_DEPTH;
		for (int n = 0; n < PERM_DEPTH; n++)
			perm[n[BYTE_W-1:0]] = n[BYTE_W-1:0];
		acc = '0;
		for (int n = 0; n < PERM_DEPTH; n++) begin
			acc = acc + perm[n[BYTE_W-1:0]] + key_mem[BYTE_W'(n % len)];
			t = perm[n[BYTE_W-1:0]];
			perm[n[BYTE_W-1:0]] = perm[acc];
			perm[acc] = t;
		end
		idx_i = '0;
		idx_j = '0;
		sched_done = 1'b1;
	endtask

	task automatic encrypt_item(cipher_item_t it);
		logic [BYTE_W-1:0] t;
		if (it.action == ACT_KEY_WRITE) begin
			key_mem[it.key_index] = it.value;
			return;
		end
		if (it.message_start || !sched_done)
			rekey();
		idx_i = idx_i + 1'b1;
		idx_j = idx_j + perm[idx_i];
		t = perm[idx_i];
		perm[idx_i] = perm[idx_j];
		perm[idx_j] = t;
		t = perm[idx_i] + perm[idx_j];
		expected_bytes.insert(expected_bytes.size(), it.value ^ perm[t]);
	endtask

	task automatic send_item(cipher_item_t it);
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid         <= 1'b1;
		item_ch.action        <= it.action;
		item_ch.value         <= it.value;
		item_ch.key_index     <= it.key_index;
		item_ch.message_start <= it.message_start;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		encrypt_item(it);
	endtask

	// lower valid, let all bytes come back and any key write settle
	task automatic drain();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_key_len(logic [LEN_W-1:0] len);
		@(negedge clk);
		cfg_ch.valid      <= 1'b1;
		cfg_ch.key_length <= len;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		key_len_reg = len;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic cipher_item_t random_item();
		cipher_item_t it;
		it.value = BYTE_W'($urandom_range(0, 255));
		it.key_index = BYTE_W'($urandom_range(0, 255));
		if ($urandom_range(0, 99) < 20) begin
			it.action = ACT_KEY_WRITE;
			it.message_start = 1'($urandom_range(0, 1));
		end else begin
			it.action = ACT_DATA;
			it.message_start = ($urandom_range(0, 39) == 0);
		end
		return it;
	endfunction

	// receiver
	always @(negedge clk)
		result_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_bytes.size() == 0) begin
				$error("out_byte: no item expected, actual %02h", result_ch.out_byte);
				fails++;
			end else if (result_ch.out_byte !== expected_bytes[0]) begin
				$error("out_byte: expected %02h, actual %02h", expected_bytes[0],
					result_ch.out_byte);
				fails++;
				void'(expected_bytes.pop_front());
			end else begin
				void'(expected_bytes.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("simulation failed");
		$finish;
	end

	initial begin
		cipher_item_t it;
		item_ch.valid         = 1'b0;
		item_ch.action        = ACT_KEY_WRITE;
		item_ch.value         = '0;
		item_ch.key_index     = '0;
		item_ch.message_start = 1'b0;
		cfg_ch.valid          = 1'b0;
		cfg_ch.key_length     = 9'd1;
		result_ch.ready       = 1'b0;
		for (int n = 0; n < PERM_DEPTH; n++) begin
			perm[n[BYTE_W-1:0]] = '0;
			key_mem[n[BYTE_W-1:0]] = '0;
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		src_idle_pct = 24;
		sink_idle_pct = 50;
		for (int r = 0; r < DIRECTED_ROWS; r++)
			send_item(directed_rows[r]);

		// fill the whole key store so every length reads written entries only
		for (int k = 0; k < PERM_DEPTH; k++) begin
			it.action = ACT_KEY_WRITE;
			it.value = BYTE_W'($urandom_range(0, 255));
			it.key_index = k[BYTE_W-1:0];
			it.message_start = 1'($urandom_range(0, 1));
			send_item(it);
		end
		drain();

		for (int p = 0; p < PHASES; p++) begin
			case (p / 3)
				0: begin
					src_idle_pct = 24;
					sink_idle_pct = 50;
				end
				1: begin
					src_idle_pct = 50;
					sink_idle_pct = 24;
				end
				default: begin
					src_idle_pct = 0;
					sink_idle_pct = 0;
				end
			endcase
			write_key_len(phase_key_len[p]);
			// open the phase with a message start so the new length is used
			it.action = ACT_DATA;
			it.value = BYTE_W'($urandom_range(0, 255));
			it.key_index = BYTE_W'($urandom_range(0, 255));
			it.message_start = 1'b1;
			send_item(it);
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_item(random_item());
			drain();
		end

		if (fails == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
